// ===== hw/rtl/hdpl_pkg.sv =====
// Shared types, codes and sizing constants for the half-duplex packet link.
package hdpl_pkg;

  localparam int TX_SLOTS_DEF      = 4;
  localparam int TX_SLOT_BYTES_DEF = 32;
  localparam int RX_BYTES_DEF      = 8;
  localparam int CMDQ_DEPTH        = 2;

  localparam logic [1:0] OP_ENQ    = 2'd0;
  localparam logic [1:0] OP_TXDONE = 2'd1;
  localparam logic [1:0] OP_RXBYTE = 2'd2;

  typedef enum logic [1:0] {
    CMD_ENQ,
    CMD_TXDONE,
    CMD_RXBYTE,
    CMD_NOP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
    logic       eom;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_out_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_TX     = 2'd1,
    KIND_RX     = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_TXRD,
    B_TXOUT,
    B_RXOUT
  } bstate_t;

endpackage

// ===== hw/rtl/half_duplex_packet_link_top.sv =====
// Top level of the half-duplex packet link: command front end and execution back end.
//
// Input channel (in_valid/in_stall): one event per transfer - enqueue an
// outgoing byte, a transmit-complete event or a byte received from the line.
// Result channel (out_valid/out_stall): each event yields one status result,
// one byte to put on the line, or the bytes of a completed received frame
// with out_frame_last on the final one.
// A two-entry command queue sits between the decoder and the back end, so
// input transfers keep landing while a result waits in the output register.
// Steps per event in the back end: a status result goes straight to the output
// register; a line byte passes through B_TXRD (slot memory read), then B_TXOUT
// (output); a received frame of N kept bytes goes through B_RXOUT, one byte per
// cycle from the receive buffer while the result channel does not stall.
// Reset (rst_n low, synchronous) empties both queues, idles the transmitter
// and restarts receive framing at a header byte; buffer contents are kept.
// A stall on the result channel holds the output register and the back end;
// the command queue then fills and in_stall rises.
module half_duplex_packet_link_top #(
  parameter int TX_SLOTS      = hdpl_pkg::TX_SLOTS_DEF,
  parameter int TX_SLOT_BYTES = hdpl_pkg::TX_SLOT_BYTES_DEF,
  parameter int RX_BYTES      = hdpl_pkg::RX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  input  logic       in_framing_error,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic       out_frame_last,
  output logic       out_tx_active,
  output logic [2:0] out_queued_messages,
  output logic       out_message_dropped,
  output logic       out_rx_overflow
);
  import hdpl_pkg::*;

  cmdq_out_t q_out;
  logic      q_pop;

  hdpl_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .in_framing_error  (in_framing_error),
    .q_out             (q_out),
    .q_pop             (q_pop)
  );

  hdpl_back #(
    .TX_SLOTS      (TX_SLOTS),
    .TX_SLOT_BYTES (TX_SLOT_BYTES),
    .RX_BYTES      (RX_BYTES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_out               (q_out),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_out_byte        (out_out_byte),
    .out_frame_last      (out_frame_last),
    .out_tx_active       (out_tx_active),
    .out_queued_messages (out_queued_messages),
    .out_message_dropped (out_message_dropped),
    .out_rx_overflow     (out_rx_overflow)
  );

endmodule

// ===== hw/rtl/hdpl_front.sv =====
// Front end: decodes input transfers into commands and holds them in a short queue.
module hdpl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_op,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_message,
  input  logic             in_framing_error,
  output hdpl_pkg::cmdq_out_t q_out,
  input  logic             q_pop
);
  import hdpl_pkg::*;

  localparam int QP_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QC_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t            q_mem [CMDQ_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  cmd_t            cmd_in;
  logic            push;
  logic            pop;

  always_comb begin
    cmd_in.data = in_data_byte;
    cmd_in.eom  = in_end_of_message;
    case (in_op)
      OP_ENQ:    cmd_in.op = CMD_ENQ;
      OP_TXDONE: cmd_in.op = in_framing_error ? CMD_NOP : CMD_TXDONE;
      OP_RXBYTE: cmd_in.op = in_framing_error ? CMD_NOP : CMD_RXBYTE;
      default:   cmd_in.op = CMD_NOP;
    endcase
  end

  assign in_stall = (cnt_r == QC_W'(CMDQ_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (cnt_r != '0);

  assign q_out.valid = (cnt_r != '0);
  assign q_out.cmd   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QP_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QP_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QC_W'(push) - QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== hw/rtl/hdpl_back.sv =====
// Back end: transmit queue, receive framer and the result output register.
module hdpl_back #(
  parameter int TX_SLOTS      = hdpl_pkg::TX_SLOTS_DEF,
  parameter int TX_SLOT_BYTES = hdpl_pkg::TX_SLOT_BYTES_DEF,
  parameter int RX_BYTES      = hdpl_pkg::RX_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hdpl_pkg::cmdq_out_t q_out,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_out_byte,
  output logic                out_frame_last,
  output logic                out_tx_active,
  output logic [2:0]          out_queued_messages,
  output logic                out_message_dropped,
  output logic                out_rx_overflow
);
  import hdpl_pkg::*;

  localparam int SLOT_W = $clog2(TX_SLOTS);
  localparam int CNT_W  = $clog2(TX_SLOTS + 1);
  localparam int FILL_W = $clog2(TX_SLOT_BYTES + 1);
  localparam int MEM_N  = TX_SLOTS * TX_SLOT_BYTES;
  localparam int ADDR_W = $clog2(MEM_N);
  localparam int RXC_W  = $clog2(RX_BYTES + 1);
  localparam int RXI_W  = $clog2(RX_BYTES);

  logic [7:0]        tx_mem [MEM_N];
  logic [7:0]        mem_q_r;
  logic [FILL_W-1:0] tx_len [TX_SLOTS];
  logic [7:0]        rx_store [RX_BYTES];

  bstate_t           state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              fdrop_r, fdrop_nxt;
  logic [FILL_W-1:0] send_r, send_nxt;
  logic              txing_r, txing_nxt;
  logic [3:0]        pend_r, pend_nxt;
  logic [RXC_W-1:0]  rxcnt_r, rxcnt_nxt;
  logic [RXC_W-1:0]  rxn_r, rxn_nxt;
  logic [RXC_W-1:0]  emit_r, emit_nxt;
  logic              dropped_r, dropped_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;

  logic              ov_r, ov_nxt;
  kind_t             okind_r, okind_nxt;
  logic [7:0]        obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;
  logic              otx_r, otx_nxt;
  logic [CNT_W-1:0]  oq_r, oq_nxt;
  logic              odrop_r, odrop_nxt;
  logic              oovf_r, oovf_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic              len_we;
  logic              rx_we;
  logic [RXI_W-1:0]  rx_wa;
  logic              out_free;
  logic [CNT_W+2:0]  oq_ext;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [FILL_W-1:0] idx);
    slot_addr = ADDR_W'(slot) * ADDR_W'(TX_SLOT_BYTES) + ADDR_W'(idx);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
    slot_inc = (slot == SLOT_W'(TX_SLOTS - 1)) ? '0 : slot + 1'b1;
  endfunction

  assign out_free = !ov_r || !out_stall;

  always_comb begin
    logic [FILL_W-1:0] si;
    logic [CNT_W-1:0]  cnt;
    logic [RXC_W-1:0]  rc;
    logic [3:0]        len;
    logic              go_tx;
    logic              go_rx;
    logic              deliver;

    si      = '0;
    cnt     = '0;
    rc      = '0;
    len     = '0;
    go_tx   = 1'b0;
    go_rx   = 1'b0;
    deliver = 1'b0;

    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    fill_nxt    = fill_r;
    fdrop_nxt   = fdrop_r;
    send_nxt    = send_r;
    txing_nxt   = txing_r;
    pend_nxt    = pend_r;
    rxcnt_nxt   = rxcnt_r;
    rxn_nxt     = rxn_r;
    emit_nxt    = emit_r;
    dropped_nxt = dropped_r;
    ovf_nxt     = ovf_r;
    rd_addr_nxt = rd_addr_r;

    ov_nxt    = ov_r && out_stall;
    okind_nxt = okind_r;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    otx_nxt   = otx_r;
    oq_nxt    = oq_r;
    odrop_nxt = odrop_r;
    oovf_nxt  = oovf_r;

    q_pop  = 1'b0;
    mem_we = 1'b0;
    mem_wa = slot_addr(tail_r, fill_r);
    len_we = 1'b0;
    rx_we  = 1'b0;
    rx_wa  = '0;

    case (state_r)
      B_IDLE: begin
        if (q_out.valid && out_free) begin
          q_pop       = 1'b1;
          dropped_nxt = 1'b0;
          ovf_nxt     = 1'b0;
          case (q_out.cmd.op)
            CMD_ENQ: begin
              if (fdrop_r || (fill_r == '0 && count_r >= CNT_W'(TX_SLOTS))) begin
                dropped_nxt = 1'b1;
                fdrop_nxt   = !q_out.cmd.eom;
              end else begin
                si = fill_r;
                if (fill_r < FILL_W'(TX_SLOT_BYTES)) begin
                  mem_we = 1'b1;
                  si     = fill_r + 1'b1;
                end
                fill_nxt = si;
                if (q_out.cmd.eom) begin
                  len_we    = 1'b1;
                  tail_nxt  = slot_inc(tail_r);
                  count_nxt = count_r + 1'b1;
                  fill_nxt  = '0;
                  if (!txing_r) begin
                    txing_nxt   = 1'b1;
                    send_nxt    = '0;
                    go_tx       = 1'b1;
                    rd_addr_nxt = slot_addr(head_r, '0);
                  end
                end
              end
            end
            CMD_TXDONE: begin
              if (txing_r) begin
                si = send_r + 1'b1;
                if (si >= tx_len[head_r]) begin
                  head_nxt  = slot_inc(head_r);
                  cnt       = (count_r != '0) ? count_r - 1'b1 : count_r;
                  count_nxt = cnt;
                  send_nxt  = '0;
                  if (cnt == '0) begin
                    txing_nxt = 1'b0;
                  end else begin
                    go_tx       = 1'b1;
                    rd_addr_nxt = slot_addr(slot_inc(head_r), '0);
                  end
                end else begin
                  send_nxt    = si;
                  go_tx       = 1'b1;
                  rd_addr_nxt = slot_addr(head_r, si);
                end
              end
            end
            CMD_RXBYTE: begin
              if (!txing_r) begin
                rc = rxcnt_r;
                if (pend_r == '0) begin
                  len = q_out.cmd.data[7:4];
                  if (len != '0) begin
                    rx_we = 1'b1;
                    rx_wa = '0;
                    rc    = RXC_W'(1);
                    if (len == 4'd1) begin
                      deliver = 1'b1;
                    end else begin
                      pend_nxt = len - 1'b1;
                    end
                  end
                end else begin
                  if (rxcnt_r < RXC_W'(RX_BYTES)) begin
                    rx_we = 1'b1;
                    rx_wa = rxcnt_r[RXI_W-1:0];
                    rc    = rxcnt_r + 1'b1;
                  end else begin
                    ovf_nxt = 1'b1;
                  end
                  pend_nxt = pend_r - 1'b1;
                  if (pend_r == 4'd1) begin
                    deliver = 1'b1;
                  end
                end
                rxcnt_nxt = rc;
                if (deliver) begin
                  rxn_nxt   = rc;
                  rxcnt_nxt = '0;
                  emit_nxt  = '0;
                  go_rx     = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          if (go_tx) begin
            state_nxt = B_TXRD;
          end else if (go_rx) begin
            state_nxt = B_RXOUT;
          end else begin
            ov_nxt    = 1'b1;
            okind_nxt = KIND_STATUS;
            obyte_nxt = '0;
            olast_nxt = 1'b0;
            otx_nxt   = txing_nxt;
            oq_nxt    = count_nxt;
            odrop_nxt = dropped_nxt;
            oovf_nxt  = ovf_nxt;
          end
        end
      end
      B_TXRD: begin
        state_nxt = B_TXOUT;
      end
      B_TXOUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_TX;
          obyte_nxt = mem_q_r;
          olast_nxt = 1'b0;
          otx_nxt   = txing_r;
          oq_nxt    = count_r;
          odrop_nxt = dropped_r;
          oovf_nxt  = ovf_r;
          state_nxt = B_IDLE;
        end
      end
      B_RXOUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_RX;
          obyte_nxt = rx_store[emit_r[RXI_W-1:0]];
          olast_nxt = (emit_r + 1'b1 == rxn_r);
          otx_nxt   = txing_r;
          oq_nxt    = count_r;
          odrop_nxt = dropped_r;
          oovf_nxt  = ovf_r;
          emit_nxt  = emit_r + 1'b1;
          if (emit_r + 1'b1 == rxn_r) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      fill_r    <= '0;
      fdrop_r   <= 1'b0;
      send_r    <= '0;
      txing_r   <= 1'b0;
      pend_r    <= '0;
      rxcnt_r   <= '0;
      rxn_r     <= '0;
      emit_r    <= '0;
      dropped_r <= 1'b0;
      ovf_r     <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      fill_r    <= fill_nxt;
      fdrop_r   <= fdrop_nxt;
      send_r    <= send_nxt;
      txing_r   <= txing_nxt;
      pend_r    <= pend_nxt;
      rxcnt_r   <= rxcnt_nxt;
      rxn_r     <= rxn_nxt;
      emit_r    <= emit_nxt;
      dropped_r <= dropped_nxt;
      ovf_r     <= ovf_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    okind_r   <= okind_nxt;
    obyte_r   <= obyte_nxt;
    olast_r   <= olast_nxt;
    otx_r     <= otx_nxt;
    oq_r      <= oq_nxt;
    odrop_r   <= odrop_nxt;
    oovf_r    <= oovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tx_mem[mem_wa] <= q_out.cmd.data;
    end
    if (state_r == B_TXRD) begin
      mem_q_r <= tx_mem[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      tx_len[tail_r] <= fill_nxt == '0 ? (fill_r < FILL_W'(TX_SLOT_BYTES) ? fill_r + 1'b1
                                                                            : fill_r)
                                       : fill_nxt;
    end
    if (rx_we) begin
      rx_store[rx_wa] <= q_out.cmd.data;
    end
  end

  assign oq_ext = (CNT_W + 3)'(oq_r);

  assign out_valid           = ov_r;
  assign out_kind            = okind_r;
  assign out_out_byte        = obyte_r;
  assign out_frame_last      = olast_r;
  assign out_tx_active       = otx_r;
  assign out_queued_messages = oq_ext[2:0];
  assign out_message_dropped = odrop_r;
  assign out_rx_overflow     = oovf_r;

endmodule

// ===== tb/hdpl_link_checker.sv =====
// Predicts link results from accepted events and compares them with the result channel.
module hdpl_link_checker #(
  parameter int TX_SLOTS      = hdpl_pkg::TX_SLOTS_DEF,
  parameter int TX_SLOT_BYTES = hdpl_pkg::TX_SLOT_BYTES_DEF,
  parameter int RX_BYTES      = hdpl_pkg::RX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  input  logic       in_framing_error,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_out_byte,
  input  logic       out_frame_last,
  input  logic       out_tx_active,
  input  logic [2:0] out_queued_messages,
  input  logic       out_message_dropped,
  input  logic       out_rx_overflow,
  output int         mismatch_count,
  output int         results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import hdpl_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic       tx_act;
    logic [2:0] queued;
    logic       dropped;
    logic       ovf;
  } link_result_t;

  logic [7:0] tx_mem [TX_SLOTS*TX_SLOT_BYTES];
  int         slot_len [TX_SLOTS];
  int         head_slot;
  int         tail_slot;
  int         queued;
  int         fill_idx;
  logic       fill_drop;
  int         send_idx;
  logic       sending;
  logic [7:0] rx_buf [RX_BYTES];
  int         rx_left;
  int         rx_kept;
  int         errors;

  link_result_t pending_link_results[$];

  assign mismatch_count = errors;

  function automatic link_result_t line_byte(int idx);
    link_result_t r;
    r = '0;
    r.kind = KIND_TX;
    r.data = tx_mem[head_slot*TX_SLOT_BYTES + ((idx >= TX_SLOT_BYTES) ? TX_SLOT_BYTES-1 : idx)];
    return r;
  endfunction

  task automatic predict_link_results(input logic [1:0] op, input logic [7:0] b,
                                      input logic eom, input logic ferr);
    link_result_t emitted[$];
    link_result_t r;
    logic         dropped;
    logic         ovf;
    logic         deliver;
    int           slot;
    dropped = 1'b0;
    ovf = 1'b0;
    deliver = 1'b0;
    case (op)
      OP_ENQ: begin
        if (fill_idx == 0 && !fill_drop && queued >= TX_SLOTS) fill_drop = 1'b1;
        if (fill_drop) begin
          dropped = 1'b1;
          if (eom) fill_drop = 1'b0;
        end else begin
          slot = tail_slot;
          if (fill_idx < TX_SLOT_BYTES) begin
            tx_mem[slot*TX_SLOT_BYTES + fill_idx] = b;
            fill_idx++;
          end
          if (eom) begin
            slot_len[slot] = fill_idx;
            tail_slot = (slot + 1) % TX_SLOTS;
            queued++;
            fill_idx = 0;
            if (!sending) begin
              sending = 1'b1;
              send_idx = 0;
              emitted.insert(emitted.size(), line_byte(0));
            end
          end
        end
      end
      OP_TXDONE: begin
        if (!ferr && sending) begin
          send_idx++;
          if (send_idx >= slot_len[head_slot]) begin
            head_slot = (head_slot + 1) % TX_SLOTS;
            if (queued > 0) queued--;
            send_idx = 0;
            if (queued == 0) sending = 1'b0;
            else emitted.insert(emitted.size(), line_byte(0));
          end else begin
            emitted.insert(emitted.size(), line_byte(send_idx));
          end
        end
      end
      OP_RXBYTE: begin
        if (!ferr && !sending) begin
          if (rx_left == 0) begin
            if (b[7:4] != 4'd0) begin
              rx_buf[0] = b;
              rx_kept = 1;
              if (b[7:4] == 4'd1) deliver = 1'b1;
              else rx_left = b[7:4] - 1;
            end
          end else begin
            if (rx_kept < RX_BYTES) begin
              rx_buf[rx_kept] = b;
              rx_kept++;
            end else begin
              ovf = 1'b1;
            end
            rx_left--;
            if (rx_left == 0) deliver = 1'b1;
          end
          if (deliver) begin
            for (int i = 0; i < rx_kept; i++) begin
              r = '0;
              r.kind = KIND_RX;
              r.data = rx_buf[i];
              r.last = (i + 1 == rx_kept);
              emitted.insert(emitted.size(), r);
            end
            rx_kept = 0;
          end
        end
      end
      default: ;
    endcase
    if (emitted.size() == 0) begin
      r = '0;
      r.kind = KIND_STATUS;
      emitted.insert(emitted.size(), r);
    end
    foreach (emitted[k]) begin
      r = emitted[k];
      r.tx_act = sending;
      r.queued = queued[2:0];
      r.dropped = dropped;
      r.ovf = ovf;
      pending_link_results.insert(pending_link_results.size(), r);
    end
  endtask

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    link_result_t want;
    if (!rst_n) begin
      head_slot = 0;
      tail_slot = 0;
      queued = 0;
      fill_idx = 0;
      fill_drop = 1'b0;
      send_idx = 0;
      sending = 1'b0;
      rx_left = 0;
      rx_kept = 0;
      pending_link_results.delete();
    end else begin
      if (in_valid && !in_stall)
        predict_link_results(in_op, in_data_byte, in_end_of_message, in_framing_error);
      if (out_valid && !out_stall) begin
        if (pending_link_results.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, got kind %0d byte %0d",
                   $time, out_kind, out_out_byte);
          errors++;
        end else begin
          want = pending_link_results[0];
          pending_link_results.delete(0);
          check_field("kind", want.kind, out_kind);
          check_field("out_byte", want.data, out_out_byte);
          check_field("frame_last", want.last, out_frame_last);
          check_field("tx_active", want.tx_act, out_tx_active);
          check_field("queued_messages", want.queued, out_queued_messages);
          check_field("message_dropped", want.dropped, out_message_dropped);
          check_field("rx_overflow", want.ovf, out_rx_overflow);
        end
      end
    end
    results_owed <= pending_link_results.size();
  end

endmodule

// ===== tb/half_duplex_packet_link_top_tb.sv =====
// Stimulus, clock, reset and verdict for the half-duplex packet link top level.
module half_duplex_packet_link_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hdpl_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         ITEM_TARGET = 240;
  localparam int         CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_op;
  logic [7:0] in_data_byte;
  logic       in_end_of_message;
  logic       in_framing_error;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_out_byte;
  logic       out_frame_last;
  logic       out_tx_active;
  logic [2:0] out_queued_messages;
  logic       out_message_dropped;
  logic       out_rx_overflow;
  int         mismatch_count;
  int         results_owed;
  int         items_sent = 0;
  int         cycle_count = 0;
  logic       calm;

  half_duplex_packet_link_top u_dut (.*);

  hdpl_link_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        hold = calm ? 0 : $urandom_range(0, 4);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic send_event(input logic [1:0] op, input logic [7:0] b,
                            input logic eom, input logic ferr);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_data_byte <= b;
    in_end_of_message <= eom;
    in_framing_error <= ferr;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_tx_done(inout int owed);
    logic ferr;
    ferr = ($urandom_range(0, 7) == 0);
    send_event(OP_TXDONE, 8'($urandom), 1'($urandom), ferr);
    if (!ferr && owed > 0) owed--;
  endtask

  task automatic send_tx_burst();
    int n_msgs;
    int len;
    int owed;
    owed = $urandom_range(2, 6);
    n_msgs = $urandom_range(1, 6);
    repeat (n_msgs) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
      owed += (len > 32) ? 32 : len;
      for (int i = 0; i < len; i++)
        send_event(OP_ENQ, 8'($urandom), i == len - 1, 1'($urandom));
      if ($urandom_range(0, 5) == 0)
        send_event(OP_RXBYTE, 8'($urandom), 1'($urandom), 1'($urandom));
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) send_tx_done(owed);
    end
    while (owed > 0) send_tx_done(owed);
  endtask

  task automatic send_rx_frame();
    int len;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    send_event(OP_RXBYTE, {4'(len), 4'($urandom)}, 1'($urandom), 1'b0);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_event(OP_RXBYTE, 8'($urandom), 1'($urandom), 1'b1);
      send_event(OP_RXBYTE, 8'($urandom), 1'($urandom), 1'b0);
    end
  endtask

  task automatic run_directed();
    send_event(OP_RXBYTE, 8'h00, 1'b0, 1'b0);
    send_event(OP_RXBYTE, 8'h1A, 1'b0, 1'b0);
    send_event(OP_RXBYTE, 8'h25, 1'b0, 1'b1);
    send_event(OP_UNUSED, 8'hFF, 1'b1, 1'b1);
    send_event(OP_TXDONE, 8'h00, 1'b0, 1'b0);
    send_event(OP_RXBYTE, 8'hA5, 1'b1, 1'b0);
    for (int i = 1; i < 10; i++)
      send_event(OP_RXBYTE, (i % 2) ? 8'hFF : 8'h00, 1'b0, 1'b0);
    send_event(OP_ENQ, 8'hFF, 1'b1, 1'b0);
    send_event(OP_ENQ, 8'h00, 1'b1, 1'b1);
    send_event(OP_ENQ, 8'h80, 1'b1, 1'b0);
    send_event(OP_ENQ, 8'h7F, 1'b1, 1'b0);
    send_event(OP_ENQ, 8'h55, 1'b1, 1'b0);
    send_event(OP_RXBYTE, 8'h31, 1'b0, 1'b0);
    send_event(OP_TXDONE, 8'h00, 1'b0, 1'b1);
    repeat (4) send_event(OP_TXDONE, 8'h00, 1'b0, 1'b0);
  endtask

  initial begin
    int pick;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_ENQ;
    in_data_byte <= 8'h00;
    in_end_of_message <= 1'b0;
    in_framing_error <= 1'b0;
    calm <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    while (items_sent < ITEM_TARGET) begin
      calm <= ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        send_tx_burst();
      end else if (pick < 8) begin
        send_rx_frame();
      end else begin
        repeat ($urandom_range(1, 4))
          send_event(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (32) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/hdpl_pkg.sv
hw/rtl/hdpl_front.sv
hw/rtl/hdpl_back.sv
hw/rtl/half_duplex_packet_link_top.sv
tb/hdpl_link_checker.sv
tb/half_duplex_packet_link_top_tb.sv
